// ===== src/utf8tc_pkg.sv =====
// Package for the UTF-8 text classifier.
// Holds the channel payload types, the running string state and the byte constants.
// No dependencies.
package utf8tc_pkg;

   // Byte ranges and masks
   localparam logic [7:0] PRINT_LO     = 8'h20;
   localparam logic [7:0] PRINT_HI     = 8'h7E;
   localparam logic [7:0] TAB_BYTE     = 8'h09;
   localparam logic [7:0] LF_BYTE      = 8'h0A;
   localparam logic [7:0] CR_BYTE      = 8'h0D;
   localparam logic [7:0] NUL_BYTE     = 8'h00;
   localparam logic [7:0] LEAD2_LO     = 8'hC2;
   localparam logic [7:0] LEAD2_HI     = 8'hDF;
   localparam logic [7:0] LEAD3_LO     = 8'hE0;
   localparam logic [7:0] LEAD3_HI     = 8'hEF;
   localparam logic [7:0] LEAD4_LO     = 8'hF0;
   localparam logic [7:0] LEAD4_HI     = 8'hF4;
   localparam logic [7:0] CONT_MASK    = 8'hC0;
   localparam logic [7:0] CONT_PATTERN = 8'h80;

   localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
   localparam logic [15:0] MIN_PRINTABLE_RST = 16'd3;

   // Continuation bytes owed after each lead class
   localparam logic [1:0] CONT_NONE  = 2'd0;
   localparam logic [1:0] CONT_LEAD2 = 2'd1;
   localparam logic [1:0] CONT_LEAD3 = 2'd2;
   localparam logic [1:0] CONT_LEAD4 = 2'd3;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic        is_text;
      logic [15:0] printable_total;
   } rsp_payload_type;

   // Running state of the string being scanned
   typedef struct packed {
      logic [1:0]  pending_continuations;
      logic        string_failed;
      logic        nul_seen;
      logic        body_seen;
      logic [15:0] printable_count;
   } scan_state_type;

endpackage

// ===== src/utf8_text_classifier.sv =====
// Top level of the UTF-8 text classifier: input register, string state, result register.
// Depends on utf8tc_pkg and utf8tc_scan.
//
// Usage:
//  - req channel: one byte of a string per item, last_byte marks its final byte.
//  - rsp channel: one verdict item per string (is_text, printable_total), sent
//    after the item that carries last_byte; other bytes give no result.
//  - csr port: csr_write_enable/csr_write_data set min_printable (reset 3).
//    Write it only while no string is in flight.
// Timing:
//  - Two register stages: a byte enters the input register, then updates the
//    string state; the verdict is registered in the result register once its
//    last byte leaves the input register.
//  - Throughput is one byte per cycle unless a last byte waits on a full result
//    slot; the only loop is the string state register updated by the byte rules.
// Reset (synchronous) empties both stages and clears the string state.
// Stall: a verdict waiting on rsp blocks only the next last byte; ordinary
// bytes keep flowing and req_ready drops only when a last byte must wait.
module utf8_text_classifier (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  utf8tc_pkg::req_payload_type  req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output utf8tc_pkg::rsp_payload_type  rsp_payload,
   input  logic                         csr_write_enable,
   input  logic [15:0]                  csr_write_data
);
   import utf8tc_pkg::*;

   req_payload_type in_ff;
   logic            in_valid_ff, in_valid_in;
   scan_state_type  state_ff, state_in, state_scan;
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     min_ff, min_in;
   logic            advance;
   logic            verdict_ok;

   // Stage 1 item moves on unless it is a last byte and the result slot is full
   assign advance   = in_valid_ff &&
                      (!in_ff.last_byte || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   utf8tc_scan u_scan (
      .state_cur  (state_ff),
      .byte_value (in_ff.byte_value),
      .state_next (state_scan)
   );

   // Verdict on the updated state
   assign verdict_ok = !state_scan.string_failed &&
                       (state_scan.pending_continuations == CONT_NONE) &&
                       state_scan.body_seen &&
                       (state_scan.printable_count >= min_ff);

   // Next values
   always_comb begin
      in_valid_in  = req_valid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      min_in       = csr_write_enable ? csr_write_data : min_ff;
      if (advance) begin
         if (in_ff.last_byte) begin
            state_in               = '0;
            rsp_in.is_text         = verdict_ok;
            rsp_in.printable_total = state_scan.printable_count;
            rsp_valid_in           = 1'b1;
         end else begin
            state_in = state_scan;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         min_ff       <= MIN_PRINTABLE_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         min_ff       <= min_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   // A last byte leaves the string state cleared
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.last_byte |=> state_ff == '0)
      else $error("string state not cleared after last byte");

   // A text verdict never reports fewer printable bytes than the threshold
   a_verdict_threshold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_text |-> rsp_ff.printable_total >= min_ff)
      else $error("text verdict below threshold");

   // No sequence can open once a NUL has been taken on a live string
   a_nul_no_pending: assert property (@(posedge clock) disable iff (reset)
      !state_ff.string_failed && state_ff.nul_seen |->
         state_ff.pending_continuations == CONT_NONE)
      else $error("pending sequence after NUL");

   // A held stage-1 item is not overwritten
   a_stage1_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
      else $error("stage 1 item lost while stalled");
`endif

endmodule

// ===== src/utf8tc_scan.sv =====
// Next-state logic for one byte of the string.
// Pure combinational; depends on utf8tc_pkg.
module utf8tc_scan (
   input  utf8tc_pkg::scan_state_type state_cur,
   input  logic [7:0]                 byte_value,
   output utf8tc_pkg::scan_state_type state_next
);
   import utf8tc_pkg::*;

   logic        is_cont;
   logic        is_print;
   logic        is_space;
   logic [15:0] count_inc;

   assign is_cont  = (byte_value & CONT_MASK) == CONT_PATTERN;
   assign is_print = (byte_value >= PRINT_LO) && (byte_value <= PRINT_HI);
   assign is_space = (byte_value == TAB_BYTE) || (byte_value == LF_BYTE) ||
                     (byte_value == CR_BYTE);

   // Saturating count step
   assign count_inc = (state_cur.printable_count == COUNT_MAX) ?
                      state_cur.printable_count :
                      state_cur.printable_count + 16'd1;

   // Byte rules; a failed string freezes
   always_comb begin
      state_next = state_cur;
      priority if (state_cur.string_failed) begin
         state_next = state_cur;
      end else if (byte_value == NUL_BYTE) begin
         if (state_cur.pending_continuations != CONT_NONE) begin
            state_next.string_failed = 1'b1;
         end else begin
            state_next.nul_seen = 1'b1;
         end
      end else if (state_cur.nul_seen) begin
         state_next.string_failed = 1'b1;
      end else if (state_cur.pending_continuations != CONT_NONE) begin
         state_next.body_seen = 1'b1;
         if (is_cont) begin
            state_next.pending_continuations = state_cur.pending_continuations - 2'd1;
            state_next.printable_count       = count_inc;
         end else begin
            state_next.string_failed = 1'b1;
         end
      end else begin
         state_next.body_seen = 1'b1;
         priority if (is_print) begin
            state_next.printable_count = count_inc;
         end else if (is_space) begin
            state_next.printable_count = state_cur.printable_count;
         end else if ((byte_value >= LEAD2_LO) && (byte_value <= LEAD2_HI)) begin
            state_next.pending_continuations = CONT_LEAD2;
            state_next.printable_count       = count_inc;
         end else if ((byte_value >= LEAD3_LO) && (byte_value <= LEAD3_HI)) begin
            state_next.pending_continuations = CONT_LEAD3;
            state_next.printable_count       = count_inc;
         end else if ((byte_value >= LEAD4_LO) && (byte_value <= LEAD4_HI)) begin
            state_next.pending_continuations = CONT_LEAD4;
            state_next.printable_count       = count_inc;
         end else begin
            state_next.string_failed = 1'b1;
         end
      end
   end

endmodule
